// ===== rtl/core/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// shared types and constants for the strongly connected component counter
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam int FW            = 11;
	localparam int MAX_VERT_DEF  = 1024;
	localparam int MAX_EDGES_DEF = 4096;

	typedef enum logic [23:0] {
		ST_IDLE    = 24'h000001,
		ST_CLR     = 24'h000002,
		ST_CNT_RD  = 24'h000004,
		ST_CNT_CHK = 24'h000008,
		ST_CNT_WR  = 24'h000010,
		ST_PFX_RD  = 24'h000020,
		ST_PFX_WR  = 24'h000040,
		ST_FIL_RD  = 24'h000080,
		ST_FIL_CHK = 24'h000100,
		ST_FIL_WR  = 24'h000200,
		ST_ROOT    = 24'h000400,
		ST_ROOT_CK = 24'h000800,
		ST_ENTER_A = 24'h001000,
		ST_ENTER_B = 24'h002000,
		ST_ENTER_C = 24'h004000,
		ST_TOP     = 24'h008000,
		ST_EDGE_A  = 24'h010000,
		ST_EDGE_B  = 24'h020000,
		ST_POP     = 24'h040000,
		ST_POPC_A  = 24'h080000,
		ST_POPC_B  = 24'h100000,
		ST_AFTER   = 24'h200000,
		ST_RES_A   = 24'h400000,
		ST_RES_B   = 24'h800000
	} state_t;

	typedef struct packed {
		state_t st;
		logic   load;
		logic   finish;
	} cmd_t;

	typedef struct packed {
		logic clr_end;
		logic cnt_end;
		logic pfx_end;
		logic edge_bad;
		logic root_end;
		logic disc_zero;
		logic has_next;
		logic is_root;
		logic pop_hit;
		logic depth_zero;
	} status_t;

endpackage

// ===== rtl/core/scc_counter.sv =====
// ----------------------------------------------------------------------------
// scc_counter
// counts the strongly connected components of a loaded directed graph
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. With op low it is an
// edge (src_vertex -> dst_vertex, vertices 1..min(vertex_count, MAX_VERTICES));
// edges load one per cycle and busy stays low, so edges may be sent back to
// back. Edges out of range or beyond the edge store capacity are dropped and
// flagged. With op high the block goes busy, clears the offset and visit
// tables, counts list lengths, forms offsets, fills the lists and runs the
// depth-first search (vertex scans, pushed vertices, edges, component stack
// pops, returns from a root and returns to a parent).
// done pulses for one cycle with scc_count and edges_dropped; busy falls at
// the end of that cycle, and the edge store is empty afterwards. The receiver
// cannot stall the result. vertex_count is to be written with cfg_we only
// while idle; the block does not enforce this. Reset clears the edge store
// count, the drop flag and sets vertex_count 1.
// ----------------------------------------------------------------------------
module scc_counter
	import scc_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERT_DEF,
	parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [FW-1:0] cfg_wdata,
	input  logic          start,
	output logic          busy,
	input  logic          op,
	input  logic [FW-1:0] src_vertex,
	input  logic [FW-1:0] dst_vertex,
	output logic          done,
	output logic [FW-1:0] scc_count,
	output logic          edges_dropped
);

	cmd_t    cmd;
	status_t sts;

	scc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	scc_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.src_vertex    (src_vertex),
		.dst_vertex    (dst_vertex),
		.cmd           (cmd),
		.done          (done),
		.sts           (sts),
		.scc_count     (scc_count),
		.edges_dropped (edges_dropped)
	);

	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op) |=> busy)
		else $error("finish transfer did not start the search");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result while idle");

	a_done_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !edges_dropped)
		else $error("drop flag kept after result");

endmodule

// ===== rtl/core/scc_ctrl.sv =====
// ----------------------------------------------------------------------------
// scc_ctrl
// sequencer for loading, list building and the depth-first search
// ----------------------------------------------------------------------------
module scc_ctrl
	import scc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    op,
	input  status_t sts,
	output cmd_t    cmd,
	output logic    busy,
	output logic    done
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (start && op) state_d = ST_CLR;
			ST_CLR:     if (sts.clr_end) state_d = ST_CNT_RD;
			ST_CNT_RD:  state_d = sts.cnt_end ? ST_PFX_RD : ST_CNT_CHK;
			ST_CNT_CHK: state_d = sts.edge_bad ? ST_CNT_RD : ST_CNT_WR;
			ST_CNT_WR:  state_d = ST_CNT_RD;
			ST_PFX_RD:  state_d = sts.pfx_end ? ST_FIL_RD : ST_PFX_WR;
			ST_PFX_WR:  state_d = ST_PFX_RD;
			ST_FIL_RD:  state_d = sts.cnt_end ? ST_ROOT : ST_FIL_CHK;
			ST_FIL_CHK: state_d = sts.edge_bad ? ST_FIL_RD : ST_FIL_WR;
			ST_FIL_WR:  state_d = ST_FIL_RD;
			ST_ROOT:    state_d = sts.root_end ? ST_IDLE : ST_ROOT_CK;
			ST_ROOT_CK: state_d = sts.disc_zero ? ST_ENTER_A : ST_ROOT;
			ST_ENTER_A: state_d = ST_ENTER_B;
			ST_ENTER_B: state_d = ST_ENTER_C;
			ST_ENTER_C: state_d = ST_TOP;
			ST_TOP:     state_d = sts.has_next ? ST_EDGE_A : ST_POP;
			ST_EDGE_A:  state_d = ST_EDGE_B;
			ST_EDGE_B:  state_d = sts.disc_zero ? ST_ENTER_A : ST_TOP;
			ST_POP:     state_d = sts.is_root ? ST_POPC_A : ST_AFTER;
			ST_POPC_A:  state_d = ST_POPC_B;
			ST_POPC_B:  state_d = sts.pop_hit ? ST_AFTER : ST_POPC_A;
			ST_AFTER:   state_d = sts.depth_zero ? ST_ROOT : ST_RES_A;
			ST_RES_A:   state_d = ST_RES_B;
			ST_RES_B:   state_d = ST_TOP;
			default:    state_d = ST_IDLE;
		endcase
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = (state_q == ST_ROOT) && sts.root_end;
	assign cmd.st     = state_q;
	assign cmd.load   = (state_q == ST_IDLE) && start && !op;
	assign cmd.finish = (state_q == ST_IDLE) && start && op;

endmodule

// ===== rtl/core/scc_dp.sv =====
// ----------------------------------------------------------------------------
// scc_dp
// edge store, adjacency lists, search stacks and counters
// ----------------------------------------------------------------------------
module scc_dp
	import scc_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERT_DEF,
	parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [FW-1:0] cfg_wdata,
	input  logic [FW-1:0] src_vertex,
	input  logic [FW-1:0] dst_vertex,
	input  cmd_t          cmd,
	input  logic          done,
	output status_t       sts,
	output logic [FW-1:0] scc_count,
	output logic          edges_dropped
);

	localparam int VIW = $clog2(MAX_VERTICES);
	localparam int VNW = $clog2(MAX_VERTICES + 1);
	localparam int VSW = $clog2(MAX_VERTICES + 2);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);

	logic [2*FW-1:0]    edge_mem  [MAX_EDGES];
	logic [ECW-1:0]     offs_mem  [MAX_VERTICES+1];
	logic [ECW-1:0]     cur_mem   [MAX_VERTICES];
	logic [VIW-1:0]     adj_mem   [MAX_EDGES];
	logic [VNW-1:0]     disc_mem  [MAX_VERTICES];
	logic [VNW-1:0]     low_mem   [MAX_VERTICES];
	logic               onstk_mem [MAX_VERTICES];
	logic [VIW-1:0]     cst_mem   [MAX_VERTICES];
	logic [VIW+ECW-1:0] call_mem  [MAX_VERTICES];

	logic [FW-1:0]      vcnt_q;
	logic [ECW-1:0]     total_q, idx_q, acc_q, nxt_q, end_q;
	logic               drop_q;
	logic [VSW-1:0]     vi_q;
	logic [VNW-1:0]     clock_q, tally_q, depth_q, comp_q, lu_q, du_q, lc_q;
	logic [VIW-1:0]     u_q, w_q;

	logic [2*FW-1:0]    edge_rd_q;
	logic [ECW-1:0]     offs_rd_q, cur_rd_q;
	logic [VIW-1:0]     adj_rd_q, cst_rd_q;
	logic [VNW-1:0]     disc_rd_q, low_rd_q;
	logic               onstk_rd_q;
	logic [VIW+ECW-1:0] call_rd_q;

	logic [VNW-1:0]     n;
	logic [FW-1:0]      es, ed;
	logic               load_bad, edge_bad, low_upd;
	logic [VIW-1:0]     cv;
	logic [ECW-1:0]     cn;

	logic               offs_we, cur_we, adj_we, disc_we, low_we, onstk_we, cst_we, call_we;
	logic [VNW-1:0]     offs_wa, offs_ra;
	logic [ECW-1:0]     offs_wd, cur_wd;
	logic [VIW-1:0]     cur_wa, cur_ra, disc_wa, disc_ra, low_wa, low_ra;
	logic [VIW-1:0]     onstk_wa, onstk_ra, cst_wa, cst_ra, call_wa, call_ra;
	logic [VNW-1:0]     disc_wd, low_wd;
	logic               onstk_wd;

	assign n = (32'(vcnt_q) > MAX_VERTICES) ? VNW'(MAX_VERTICES) : VNW'(vcnt_q);

	assign es       = edge_rd_q[2*FW-1:FW];
	assign ed       = edge_rd_q[FW-1:0];
	assign load_bad = (src_vertex == '0) || (dst_vertex == '0) ||
		(32'(src_vertex) > 32'(n)) || (32'(dst_vertex) > 32'(n)) ||
		(32'(total_q) >= MAX_EDGES);
	assign edge_bad = (es == '0) || (ed == '0) || (32'(es) > 32'(n)) || (32'(ed) > 32'(n));
	assign cv       = call_rd_q[VIW+ECW-1:ECW];
	assign cn       = call_rd_q[ECW-1:0];
	assign low_upd  = (disc_rd_q != '0) && onstk_rd_q && (disc_rd_q < lu_q);

	assign sts.clr_end    = (32'(vi_q) == 32'(n));
	assign sts.cnt_end    = (idx_q == total_q);
	assign sts.pfx_end    = (32'(vi_q) > 32'(n));
	assign sts.edge_bad   = edge_bad;
	assign sts.root_end   = (32'(vi_q) == 32'(n));
	assign sts.disc_zero  = (disc_rd_q == '0);
	assign sts.has_next   = (nxt_q < end_q);
	assign sts.is_root    = (lu_q == du_q);
	assign sts.pop_hit    = (cst_rd_q == u_q);
	assign sts.depth_zero = (depth_q == '0);

	assign scc_count     = (32'(tally_q) > 2047) ? '1 : FW'(tally_q);
	assign edges_dropped = drop_q;

	always_comb begin
		offs_we  = 1'b0;
		offs_wa  = VNW'(vi_q);
		offs_wd  = '0;
		offs_ra  = VNW'(vi_q);
		cur_we   = 1'b0;
		cur_wa   = VIW'(vi_q - 1);
		cur_wd   = acc_q;
		cur_ra   = VIW'(es - 1);
		adj_we   = 1'b0;
		disc_we  = 1'b0;
		disc_wa  = VIW'(vi_q);
		disc_wd  = '0;
		disc_ra  = VIW'(vi_q);
		low_we   = 1'b0;
		low_wa   = u_q;
		low_wd   = disc_rd_q;
		low_ra   = cv;
		onstk_we = 1'b0;
		onstk_wa = VIW'(vi_q);
		onstk_wd = 1'b0;
		onstk_ra = adj_rd_q;
		cst_we   = 1'b0;
		cst_wa   = VIW'(comp_q);
		cst_ra   = VIW'(comp_q - 1);
		call_we  = 1'b0;
		call_wa  = VIW'(depth_q - 1);
		call_ra  = VIW'(depth_q - 1);
		unique case (cmd.st)
			ST_CLR: begin
				offs_we = 1'b1;
				if (32'(vi_q) < 32'(n)) begin
					disc_we  = 1'b1;
					onstk_we = 1'b1;
				end
			end
			ST_CNT_CHK: offs_ra = VNW'(es);
			ST_CNT_WR: begin
				offs_we = 1'b1;
				offs_wa = VNW'(es);
				offs_wd = offs_rd_q + ECW'(1);
			end
			ST_PFX_WR: begin
				offs_we = 1'b1;
				offs_wd = acc_q + offs_rd_q;
				cur_we  = 1'b1;
			end
			ST_FIL_WR: begin
				adj_we = 1'b1;
				cur_we = 1'b1;
				cur_wa = VIW'(es - 1);
				cur_wd = cur_rd_q + ECW'(1);
			end
			ST_ENTER_A: begin
				call_we = (depth_q != '0);
				offs_ra = VNW'(w_q);
			end
			ST_ENTER_B: offs_ra = VNW'(w_q) + VNW'(1);
			ST_ENTER_C: begin
				disc_we  = 1'b1;
				disc_wa  = w_q;
				disc_wd  = clock_q + VNW'(1);
				low_we   = 1'b1;
				low_wa   = w_q;
				low_wd   = clock_q + VNW'(1);
				onstk_we = 1'b1;
				onstk_wa = w_q;
				onstk_wd = 1'b1;
				cst_we   = 1'b1;
			end
			ST_EDGE_A: disc_ra = adj_rd_q;
			ST_EDGE_B: low_we = low_upd;
			ST_POPC_B: begin
				onstk_we = 1'b1;
				onstk_wa = cst_rd_q;
			end
			ST_RES_A: begin
				disc_ra = cv;
				offs_ra = VNW'(cv) + VNW'(1);
			end
			ST_RES_B: begin
				low_we = (lc_q < low_rd_q);
				low_wd = lc_q;
			end
			default: begin
			end
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.load && !load_bad) edge_mem[total_q[EAW-1:0]] <= {src_vertex, dst_vertex};
		edge_rd_q <= edge_mem[idx_q[EAW-1:0]];
		if (offs_we) offs_mem[offs_wa] <= offs_wd;
		offs_rd_q <= offs_mem[offs_ra];
		if (cur_we) cur_mem[cur_wa] <= cur_wd;
		cur_rd_q <= cur_mem[cur_ra];
		if (adj_we) adj_mem[cur_rd_q[EAW-1:0]] <= VIW'(ed - 1);
		adj_rd_q <= adj_mem[nxt_q[EAW-1:0]];
		if (disc_we) disc_mem[disc_wa] <= disc_wd;
		disc_rd_q <= disc_mem[disc_ra];
		if (low_we) low_mem[low_wa] <= low_wd;
		low_rd_q <= low_mem[low_ra];
		if (onstk_we) onstk_mem[onstk_wa] <= onstk_wd;
		onstk_rd_q <= onstk_mem[onstk_ra];
		if (cst_we) cst_mem[cst_wa] <= w_q;
		cst_rd_q <= cst_mem[cst_ra];
		if (call_we) call_mem[call_wa] <= {u_q, nxt_q};
		call_rd_q <= call_mem[call_ra];
	end

	// payload registers of the search
	always_ff @(posedge clk) begin
		unique case (cmd.st)
			ST_CNT_RD:  if (sts.cnt_end) acc_q <= '0;
			ST_PFX_WR:  acc_q <= acc_q + offs_rd_q;
			ST_ROOT_CK: if (sts.disc_zero) w_q <= VIW'(vi_q);
			ST_ENTER_B: nxt_q <= offs_rd_q;
			ST_ENTER_C: begin
				end_q <= offs_rd_q;
				u_q   <= w_q;
				lu_q  <= clock_q + VNW'(1);
				du_q  <= clock_q + VNW'(1);
			end
			ST_TOP:     if (sts.has_next) nxt_q <= nxt_q + ECW'(1);
			ST_EDGE_A:  w_q <= adj_rd_q;
			ST_EDGE_B:  if (low_upd) lu_q <= disc_rd_q;
			ST_RES_A: begin
				u_q   <= cv;
				nxt_q <= cn;
				lc_q  <= lu_q;
			end
			ST_RES_B: begin
				lu_q  <= (lc_q < low_rd_q) ? lc_q : low_rd_q;
				du_q  <= disc_rd_q;
				end_q <= offs_rd_q;
			end
			default: begin
			end
		endcase
	end

	// counters and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q  <= FW'(1);
			total_q <= '0;
			drop_q  <= 1'b0;
			idx_q   <= '0;
			vi_q    <= '0;
			clock_q <= '0;
			tally_q <= '0;
			depth_q <= '0;
			comp_q  <= '0;
		end else begin
			if (cfg_we) vcnt_q <= cfg_wdata;
			if (cmd.load) begin
				if (load_bad) drop_q <= 1'b1;
				else total_q <= total_q + ECW'(1);
			end
			if (cmd.finish) begin
				idx_q   <= '0;
				vi_q    <= '0;
				clock_q <= '0;
				tally_q <= '0;
				depth_q <= '0;
				comp_q  <= '0;
			end
			if (done) begin
				total_q <= '0;
				drop_q  <= 1'b0;
			end
			unique case (cmd.st)
				ST_CLR:     vi_q <= vi_q + VSW'(1);
				ST_CNT_RD:  if (sts.cnt_end) vi_q <= VSW'(1);
				ST_CNT_CHK: begin
					if (edge_bad) begin
						drop_q <= 1'b1;
						idx_q  <= idx_q + ECW'(1);
					end
				end
				ST_CNT_WR:  idx_q <= idx_q + ECW'(1);
				ST_PFX_RD:  if (sts.pfx_end) idx_q <= '0;
				ST_PFX_WR:  vi_q <= vi_q + VSW'(1);
				ST_FIL_RD:  if (sts.cnt_end) vi_q <= '0;
				ST_FIL_CHK: if (edge_bad) idx_q <= idx_q + ECW'(1);
				ST_FIL_WR:  idx_q <= idx_q + ECW'(1);
				ST_ROOT_CK: if (!sts.disc_zero) vi_q <= vi_q + VSW'(1);
				ST_ENTER_C: begin
					clock_q <= clock_q + VNW'(1);
					comp_q  <= comp_q + VNW'(1);
					depth_q <= depth_q + VNW'(1);
				end
				ST_POP: begin
					depth_q <= depth_q - VNW'(1);
					if (sts.is_root) tally_q <= tally_q + VNW'(1);
				end
				ST_POPC_A:  comp_q <= comp_q - VNW'(1);
				ST_AFTER:   if (sts.depth_zero) vi_q <= vi_q + VSW'(1);
				default: begin
				end
			endcase
		end
	end

endmodule
